@@ rtl/swf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swf_pkg
// Shared types, constants and helper functions of the skyline window filter.
// ----------------------------------------------------------------------------
package swf_pkg;

    localparam int SLOTS    = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int ID_W     = 16;
    localparam int PRICE_W  = 24;
    localparam int RATING_W = 16;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply;
        logic dump_emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic dump_last;
    } t_sts;

    function automatic logic dominates(
        input logic [PRICE_W-1:0]  pa,
        input logic [RATING_W-1:0] ra,
        input logic [PRICE_W-1:0]  pb,
        input logic [RATING_W-1:0] rb
    );
        return (pa <= pb) && (ra >= rb) && ((pa < pb) || (ra > rb));
    endfunction

    function automatic logic [SLOT_W-1:0] first_index(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

@@ rtl/swf_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swf_ctrl
// Controller: sequences insert (capture, apply) and dump (emit per slot).
// ----------------------------------------------------------------------------
module swf_ctrl
    import swf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_action,
    output logic      o_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_action == ACT_DUMP) ? ST_DUMP : ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_DUMP: begin
                if (i_sts.out_free) begin
                    o_cmd.dump_emit = 1'b1;
                    if (i_sts.dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/swf_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swf_datapath
// Window slots, parallel dominance compare, insert/replace and dump output.
// ----------------------------------------------------------------------------
module swf_datapath
    import swf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [ID_W-1:0]     i_point_id,
    input  wire logic [PRICE_W-1:0]  i_point_price,
    input  wire logic [RATING_W-1:0] i_point_rating,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [ID_W-1:0]          o_out_id,
    output logic [PRICE_W-1:0]       o_out_price,
    output logic [RATING_W-1:0]      o_out_rating,
    output logic                     o_is_last,
    output logic                     o_is_empty,
    output logic                     o_overflowed
);

    logic [SLOTS-1:0]    r_slot_valid;
    logic [ID_W-1:0]     r_slot_id     [SLOTS];
    logic [PRICE_W-1:0]  r_slot_price  [SLOTS];
    logic [RATING_W-1:0] r_slot_rating [SLOTS];
    logic                r_ovf;

    logic [ID_W-1:0]     r_pt_id;
    logic [PRICE_W-1:0]  r_pt_price;
    logic [RATING_W-1:0] r_pt_rating;
    logic [SLOTS-1:0]    r_kill;
    logic [SLOTS-1:0]    r_match;
    logic                r_drop;

    logic [SLOTS-1:0]    n_kill;
    logic [SLOTS-1:0]    n_match;
    logic                n_drop;

    logic [SLOTS-1:0]    w_remain;
    logic [SLOTS-1:0]    w_match;
    logic                w_has_match;
    logic                w_has_free;
    logic [SLOT_W-1:0]   w_target;
    logic                w_write;
    logic                w_overflow;

    logic [SLOT_W-1:0]   w_pick;
    logic [SLOTS-1:0]    w_after_pick;
    logic                w_empty;

    always_comb begin
        n_kill  = '0;
        n_match = '0;
        n_drop  = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_slot_valid[i]) begin
                if (dominates(r_slot_price[i], r_slot_rating[i],
                              i_point_price, i_point_rating)) begin
                    n_drop = 1'b1;
                end
                n_kill[i]  = dominates(i_point_price, i_point_rating,
                                       r_slot_price[i], r_slot_rating[i]);
                n_match[i] = (r_slot_id[i] == i_point_id);
            end
        end
    end

    assign w_remain    = r_slot_valid & ~r_kill;
    assign w_match     = r_match & ~r_kill;
    assign w_has_match = |w_match;
    assign w_has_free  = ~&w_remain;
    assign w_target    = w_has_match ? first_index(w_match) : first_index(~w_remain);
    assign w_write     = i_cmd.apply && !r_drop && (w_has_match || w_has_free);
    assign w_overflow  = i_cmd.apply && !r_drop && !w_has_match && !w_has_free;

    assign w_pick       = first_index(r_slot_valid);
    assign w_after_pick = r_slot_valid & (r_slot_valid - SLOTS'(1));
    assign w_empty      = ~|r_slot_valid;

    assign o_sts.out_free  = !o_valid || i_ready;
    assign o_sts.dump_last = (w_after_pick == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pt_id     <= i_point_id;
            r_pt_price  <= i_point_price;
            r_pt_rating <= i_point_rating;
            r_kill      <= n_kill;
            r_match     <= n_match;
            r_drop      <= n_drop;
        end
        if (w_write) begin
            r_slot_id[w_target]     <= r_pt_id;
            r_slot_price[w_target]  <= r_pt_price;
            r_slot_rating[w_target] <= r_pt_rating;
        end
        if (i_cmd.dump_emit) begin
            o_out_id     <= w_empty ? '0 : r_slot_id[w_pick];
            o_out_price  <= w_empty ? '0 : r_slot_price[w_pick];
            o_out_rating <= w_empty ? '0 : r_slot_rating[w_pick];
            o_is_last    <= (w_after_pick == '0);
            o_is_empty   <= w_empty;
            o_overflowed <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_ovf        <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (i_cmd.apply && !r_drop) begin
                r_slot_valid <= w_remain | (w_write ? (SLOTS'(1) << w_target) : '0);
            end else if (i_cmd.dump_emit) begin
                r_slot_valid <= w_after_pick;
            end
            if (w_overflow) begin
                r_ovf <= 1'b1;
            end else if (i_cmd.dump_emit && (w_after_pick == '0)) begin
                r_ovf <= 1'b0;
            end
            if (i_cmd.dump_emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dump_emit |-> (!o_valid || i_ready))
        else $error("dump result loaded over a stalled result");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dump_emit && o_sts.dump_last |=> (r_slot_valid == '0) && !r_ovf)
        else $error("window not cleared after last dump result");

    a_overflow_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_overflow |-> ((r_kill & r_slot_valid) == '0) && (r_slot_valid == '1))
        else $error("overflow raised while a slot was free");

    a_drop_keeps_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply && r_drop |=> $stable(r_slot_valid))
        else $error("dominated point changed the window");

endmodule
`default_nettype wire

@@ rtl/skyline_window_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skyline_window_filter
// Two-dimensional skyline filter over a window of point slots.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one item per handshake. i_action selects
// insert of a point (id, price, rating) or dump of the window.
// For an insert the accept edge registers the parallel dominance compare
// against all slots; unless the point is dominated, the next cycle removes dominated
// entries and writes it. No result is produced; o_ready is low in that cycle.
// A dump emits one result per valid slot in slot order (one empty-marked
// result if the window holds nothing), one result per cycle while the
// receiver takes them; the slot scan picks the lowest remaining valid slot
// for each result. The last result carries o_is_last; the window and the
// overflow flag clear as it is loaded.
// Output channel (o_valid/i_ready): results sit in an output register; when
// the receiver stalls, the dump holds and the input stays closed. After the
// last result is loaded the block takes a new item even while it waits.
// Reset (synchronous, active low) empties the window, clears the overflow
// flag and drops any pending result.
// ----------------------------------------------------------------------------
module skyline_window_filter
    import swf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_action,
    input  wire logic [ID_W-1:0]     i_point_id,
    input  wire logic [PRICE_W-1:0]  i_point_price,
    input  wire logic [RATING_W-1:0] i_point_rating,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [ID_W-1:0]          o_out_id,
    output logic [PRICE_W-1:0]       o_out_price,
    output logic [RATING_W-1:0]      o_out_rating,
    output logic                     o_is_last,
    output logic                     o_is_empty,
    output logic                     o_overflowed
);

    t_cmd w_cmd;
    t_sts w_sts;

    swf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    swf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_point_id     (i_point_id),
        .i_point_price  (i_point_price),
        .i_point_rating (i_point_rating),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_id       (o_out_id),
        .o_out_price    (o_out_price),
        .o_out_rating   (o_out_rating),
        .o_is_last      (o_is_last),
        .o_is_empty     (o_is_empty),
        .o_overflowed   (o_overflowed)
    );

endmodule
`default_nettype wire
